/* hdl/fp16srgb_pkg.sv */
// Shared widths and constants for the half-float to sRGB8 pixel pipeline.
`default_nettype none

package fp16srgb_pkg;

  // Field widths of a beat
  localparam int HalfW = 16;
  localparam int ByteW = 8;
  localparam int WsW   = 18;

  // binary16 layout
  localparam int MantW    = 10;
  localparam int ExpW     = 5;
  localparam int HalfBias = 15;
  localparam int SigW     = MantW + 1;

  // White scale is Q2.16, unity after reset
  localparam int           WsFracBits = 16;
  localparam logic [WsW-1:0] WsReset  = WsW'(1) << WsFracBits;

  // Linear light precision, default
  localparam int LinFracBitsDef = 16;

  // Product of significand and gain, and the zero padding put under it so
  // that every exponent becomes a right shift of at least one place
  localparam int ProdW    = SigW + WsW;
  localparam int PreShift = 30;
  localparam int PadW     = ProdW + PreShift;
  localparam int RmW      = $clog2(PadW);

  // One code bit is settled per search stage
  localparam int NumSearch = ByteW;
  localparam int NumCodes  = 1 << ByteW;
  localparam int NumStages = 2 + NumSearch;

  localparam logic [ByteW-1:0] AlphaOpaque = '1;

endpackage

`default_nettype wire

/* hdl/fp16srgb_pix_in_if.sv */
// Input pixel channel: three half-float colour channels and the frame mark.
`default_nettype none

interface fp16srgb_pix_in_if
  import fp16srgb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] red_half;
  logic [HalfW-1:0] green_half;
  logic [HalfW-1:0] blue_half;
  logic             last_pixel;

  modport source (output valid, red_half, green_half, blue_half, last_pixel,
                  input ready);
  modport sink   (input valid, red_half, green_half, blue_half, last_pixel,
                  output ready);
endinterface

`default_nettype wire

/* hdl/fp16srgb_pix_out_if.sv */
// Output pixel channel: BGRA bytes and the frame mark.
`default_nettype none

interface fp16srgb_pix_out_if
  import fp16srgb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] blue_byte;
  logic [ByteW-1:0] green_byte;
  logic [ByteW-1:0] red_byte;
  logic [ByteW-1:0] alpha_byte;
  logic             last_pixel_out;

  modport source (output valid, blue_byte, green_byte, red_byte, alpha_byte,
                  last_pixel_out, input ready);
  modport sink   (input valid, blue_byte, green_byte, red_byte, alpha_byte,
                  last_pixel_out, output ready);
endinterface

`default_nettype wire

/* hdl/fp16_linear_to_srgb8_pixel_unit.sv */
// Pixel converter: linear scRGB half floats in, 8-bit sRGB BGRA out.
// Throughput: one pixel per cycle while the output is not stalled; the
// eight-stage code search (one bit per stage) and the decode/gain and round
// stages before it form the pipeline.
// Each stage moves on when it is empty or the stage after it moves on.
// Reset clears all stage valid bits and sets the white scale to unity.
`default_nettype none

module fp16_linear_to_srgb8_pixel_unit
  import fp16srgb_pkg::*;
#(
  parameter int LinFracBits = LinFracBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  fp16srgb_pix_in_if.sink          pix_i,
  fp16srgb_pix_out_if.source       pix_o,
  input  wire logic                white_scale_we_i,
  input  wire logic [WsW-1:0]      white_scale_i
);

  // White scale register
  logic [WsW-1:0] ws_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= WsReset;
    end else if (white_scale_we_i) begin
      ws_q <= white_scale_i;
    end
  end

  // Advance each stage when it is empty or its successor advances
  logic [NumStages-1:0] adv;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] last_q;

  always_comb begin
    adv[NumStages-1] = ~vld_q[NumStages-1] | pix_o.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = ~vld_q[i] | adv[i+1];
    end
  end

  assign pix_i.ready = adv[0];

  // Carry valid bits down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= pix_i.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Carry the frame mark alongside
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      last_q[0] <= pix_i.last_pixel;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (adv[i]) begin
        last_q[i] <= last_q[i-1];
      end
    end
  end

  // One datapath per colour channel
  logic [ByteW-1:0] red_code;
  logic [ByteW-1:0] green_code;
  logic [ByteW-1:0] blue_code;

  fp16srgb_chan #(.LinFracBits(LinFracBits)) u_red (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .half_i        (pix_i.red_half),
    .white_scale_i (ws_q),
    .code_o        (red_code)
  );

  fp16srgb_chan #(.LinFracBits(LinFracBits)) u_green (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .half_i        (pix_i.green_half),
    .white_scale_i (ws_q),
    .code_o        (green_code)
  );

  fp16srgb_chan #(.LinFracBits(LinFracBits)) u_blue (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .half_i        (pix_i.blue_half),
    .white_scale_i (ws_q),
    .code_o        (blue_code)
  );

  // Output beat
  assign pix_o.valid          = vld_q[NumStages-1];
  assign pix_o.blue_byte      = blue_code;
  assign pix_o.green_byte     = green_code;
  assign pix_o.red_byte       = red_code;
  assign pix_o.alpha_byte     = AlphaOpaque;
  assign pix_o.last_pixel_out = last_q[NumStages-1];

  // An empty output stage never holds back the input
  a_ready_when_drained : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NumStages-1] |-> pix_i.ready
  ) else $error("input stalled with an empty output stage");

  // An accepted beat lands in the first stage
  a_accept_enters : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> vld_q[0]
  ) else $error("accepted beat lost at pipeline entry");

  // A taken output with nothing behind it leaves the output empty
  a_output_drains : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.ready && !vld_q[NumStages-2]) |=> !pix_o.valid
  ) else $error("output beat repeated");

  // A beat in the stage before the output moves on when the output is taken
  a_feed_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-2] && pix_o.ready) |=> pix_o.valid
  ) else $error("beat lost before the output stage");

endmodule

`default_nettype wire

/* hdl/fp16srgb_chan.sv */
// Datapath of one colour channel: decode, gain, round to linear, sRGB search.
`default_nettype none

module fp16srgb_chan
  import fp16srgb_pkg::*;
#(
  parameter int LinFracBits = LinFracBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic [NumStages-1:0] adv_i,
  input  wire logic [HalfW-1:0]     half_i,
  input  wire logic [WsW-1:0]       white_scale_i,
  output      logic [ByteW-1:0]     code_o
);

  localparam int LinW = LinFracBits + 1;
  localparam logic [LinW-1:0] LinOne = LinW'(1) << LinFracBits;
  // Right shift (less one) that brings the padded product to Q1.LinFracBits
  localparam int RBase = PreShift + HalfBias + MantW + WsFracBits - LinFracBits - 1;

  typedef logic [NumCodes-1:0][LinW-1:0] thr_tab_t;

  // Smallest linear value that reaches each code; entry 0 is never used
  function automatic thr_tab_t calc_thr();
    logic [319:0] c12;
    logic [319:0] rhs;
    logic [319:0] lhs;
    logic [63:0]  num;
    thr_tab_t     tab;
    int           lo;
    int           hi;
    int           mid;
    tab = '0;
    c12 = 320'd1;
    for (int i = 0; i < 12; i++) begin
      c12 = c12 * 320'd10761;
    end
    for (int k = 1; k < NumCodes; k++) begin
      if (k <= 10) begin
        // linear segment: lin * 658920 >= (2k - 1) * 100 * 2^F
        num = 64'((2 * k - 1) * 100) << LinFracBits;
        tab[k] = LinW'((num + 64'd658919) / 64'd658920);
      end else begin
        // power segment: lin^5 * 10761^12 >= (40k + 541)^12 * 2^(5F)
        rhs = 320'd1;
        for (int i = 0; i < 12; i++) begin
          rhs = rhs * 320'(40 * k + 541);
        end
        rhs = rhs << (5 * LinFracBits);
        lo = 0;
        hi = 1 << LinFracBits;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          lhs = 320'(mid);
          lhs = lhs * lhs * lhs * lhs * lhs * c12;
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        tab[k] = LinW'(lo);
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t Thr = calc_thr();

  // Stage 0: decode the half and multiply significand by the gain
  logic             sign;
  logic [ExpW-1:0]  expo;
  logic [MantW-1:0] mant;
  logic             expo_max;
  logic [ExpW-1:0]  expo_eff;
  logic [SigW-1:0]  sig;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [RmW-1:0]   rm1_d, rm1_q;
  logic             zero_d, zero_q;
  logic             inf_d, inf_q;

  assign sign     = half_i[HalfW-1];
  assign expo     = half_i[MantW +: ExpW];
  assign mant     = half_i[MantW-1:0];
  assign expo_max = (expo == '1);
  assign expo_eff = (expo == '0) ? ExpW'(1) : expo;
  assign sig      = {(expo != '0), mant};
  assign prod_d   = ProdW'(sig) * ProdW'(white_scale_i);
  assign rm1_d    = RmW'(RBase) - RmW'(expo_eff);
  assign zero_d   = sign | (expo_max & (mant != '0));
  assign inf_d    = expo_max & ~sign & (mant == '0);

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      prod_q <= prod_d;
      rm1_q  <= rm1_d;
      zero_q <= zero_d;
      inf_q  <= inf_d;
    end
  end

  // Stage 1: shift, round half up and saturate at one; negative and NaN inputs give zero
  logic [PadW-1:0] padded;
  logic [PadW-1:0] shifted;
  logic [PadW-1:0] rounded;
  logic [LinW-1:0] lin_d;
  logic [NumSearch-1:0][LinW-1:0] lin_q;

  assign padded  = {prod_q, PreShift'(0)};
  assign shifted = padded >> rm1_q;
  assign rounded = (shifted + PadW'(1)) >> 1;

  always_comb begin
    priority if (zero_q) begin
      lin_d = '0;
    end else if (inf_q) begin
      // infinity times a zero gain has no value and reads as black
      lin_d = (prod_q != '0) ? LinOne : '0;
    end else if (rounded > PadW'(LinOne)) begin
      lin_d = LinOne;
    end else begin
      lin_d = rounded[LinW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      lin_q[0] <= lin_d;
    end
  end

  // Stages 2 onward: settle one code bit per stage, most significant first
  logic [NumSearch-1:0][ByteW-1:0] code_q;

  for (genvar j = 0; j < NumSearch; j++) begin : g_search
    logic [ByteW-1:0] prev;
    logic [ByteW-1:0] cand;
    logic [ByteW-1:0] code_d;

    if (j == 0) begin : g_first
      assign prev = '0;
    end else begin : g_next
      assign prev = code_q[j-1];
    end

    assign cand   = prev | (ByteW'(1) << (NumSearch - 1 - j));
    assign code_d = (lin_q[j] >= Thr[cand]) ? cand : prev;

    always_ff @(posedge clk_i) begin
      if (adv_i[2+j]) begin
        code_q[j] <= code_d;
      end
    end

    if (j < NumSearch - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (adv_i[2+j]) begin
          lin_q[j+1] <= lin_q[j];
        end
      end
    end
  end

  assign code_o = code_q[NumSearch-1];

endmodule

`default_nettype wire
